[design/tlas_pkg.sv]
// tone light alert sequencer package: step and result types, trigger codes,
// fixed alert pattern tables and error pattern step constants
// no dependencies
package tlas_pkg;

    // input item kinds, also used as the code of the pattern in play
    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_INIT    = 3'd1,
        MODE_HINT    = 3'd2,
        MODE_LOST    = 3'd3,
        MODE_RECOVER = 3'd4,
        MODE_ERROR   = 3'd5
    } mode_t;

    // system modes that the sequencer looks at
    localparam logic [2:0] SYS_INIT   = 3'd0;
    localparam logic [2:0] SYS_NORMAL = 3'd1;

    // configuration register indexes
    localparam logic [2:0] CFG_BEEPS_CHASSIS = 3'd0;
    localparam logic [2:0] CFG_BEEPS_GIMBAL  = 3'd1;
    localparam logic [2:0] CFG_BEEPS_SHOOTER = 3'd2;
    localparam logic [2:0] CFG_BEEPS_VISION  = 3'd3;
    localparam logic [2:0] CFG_BEEPS_IMU     = 3'd4;

    localparam int NUM_MODULES = 5;

    // one pattern step as kept in the step store
    typedef struct packed {
        logic [11:0] tone;
        logic [9:0]  dur;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } step_t;

    localparam int STEP_W = $bits(step_t);

    // one result transaction, buzzer_write in the lowest bit
    typedef struct packed {
        logic        playing;
        logic [7:0]  led_blue;
        logic [7:0]  led_green;
        logic [7:0]  led_red;
        logic        led_breathing;
        logic        led_write;
        logic [11:0] buzzer_freq;
        logic        buzzer_write;
    } result_t;

    // request from the control logic to the pattern loader
    typedef struct packed {
        logic       start;
        mode_t      code;
        logic [4:0] mask;
    } bld_req_t;

    // error pattern steps
    localparam step_t BEEP_STEP  = '{tone: 12'd3000, dur: 10'd80,
                                     red: 8'd255, green: 8'd0, blue: 8'd0};
    localparam logic [9:0] GAP_DUR      = 10'd60;
    localparam logic [9:0] GAP_LAST_DUR = 10'd800;

    function automatic step_t mk_step(input logic [11:0] tone, input logic [9:0] dur,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        step_t s;
        s.tone  = tone;
        s.dur   = dur;
        s.red   = r;
        s.green = g;
        s.blue  = b;
        return s;
    endfunction

    // fixed pattern table; the error code holds the yellow fallback
    function automatic step_t pattern_step(input mode_t code, input logic [2:0] idx);
        step_t s;
        s = '0;
        case (code)
            MODE_INIT:
            begin
                case (idx)
                    3'd0:    s = mk_step(12'd880,  10'd170, 8'd255, 8'd0,   8'd0);
                    3'd1:    s = mk_step(12'd0,    10'd50,  8'd0,   8'd200, 8'd200);
                    3'd2:    s = mk_step(12'd1100, 10'd170, 8'd0,   8'd0,   8'd255);
                    3'd3:    s = mk_step(12'd0,    10'd50,  8'd0,   8'd0,   8'd255);
                    3'd4:    s = mk_step(12'd1320, 10'd400, 8'd0,   8'd255, 8'd0);
                    default: s = '0;
                endcase
            end
            MODE_HINT:
            begin
                case (idx)
                    3'd0:    s = mk_step(12'd2500, 10'd120, 8'd0, 8'd255, 8'd0);
                    3'd1:    s = mk_step(12'd0,    10'd20,  8'd0, 8'd0,   8'd0);
                    3'd2:    s = mk_step(12'd3000, 10'd180, 8'd0, 8'd255, 8'd0);
                    default: s = '0;
                endcase
            end
            MODE_LOST:
            begin
                case (idx)
                    3'd0:    s = mk_step(12'd1500, 10'd200, 8'd0, 8'd0, 8'd255);
                    3'd1:    s = mk_step(12'd0,    10'd50,  8'd0, 8'd0, 8'd0);
                    3'd2:    s = mk_step(12'd1500, 10'd200, 8'd0, 8'd0, 8'd255);
                    default: s = '0;
                endcase
            end
            MODE_RECOVER:
            begin
                case (idx)
                    3'd0:    s = mk_step(12'd2500, 10'd150, 8'd0, 8'd0,   8'd255);
                    3'd1:    s = mk_step(12'd0,    10'd40,  8'd0, 8'd0,   8'd0);
                    3'd2:    s = mk_step(12'd3000, 10'd150, 8'd0, 8'd255, 8'd0);
                    default: s = '0;
                endcase
            end
            MODE_ERROR:
            begin
                case (idx)
                    3'd0:    s = mk_step(12'd3000, 10'd500, 8'd255, 8'd200, 8'd0);
                    3'd1:    s = mk_step(12'd0,    10'd500, 8'd0,   8'd0,   8'd0);
                    default: s = '0;
                endcase
            end
            default: s = '0;
        endcase
        return s;
    endfunction

    // number of steps of each fixed pattern
    function automatic logic [2:0] pattern_len(input mode_t code);
        logic [2:0] n;
        case (code)
            MODE_INIT:    n = 3'd5;
            MODE_HINT:    n = 3'd3;
            MODE_LOST:    n = 3'd3;
            MODE_RECOVER: n = 3'd3;
            MODE_ERROR:   n = 3'd2;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    // loader states
    typedef enum logic [1:0] {
        BLD_IDLE,
        BLD_FIXED,
        BLD_ERR
    } bld_state_t;

    // control states
    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_READ,
        TOP_LOAD
    } top_state_t;

endpackage

[design/tlas_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module tlas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/tlas_builder.sv]
// pattern loader: writes a fixed pattern or a built error pattern into the
// step store, one step per cycle but pausing between modules; depends on tlas_pkg
module tlas_builder #(
    parameter int STEP_SLOTS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlas_pkg::bld_req_t                req,
    input  logic [tlas_pkg::NUM_MODULES-1:0][3:0] beeps,
    output logic                              wr_en,
    output logic [$clog2(STEP_SLOTS)-1:0]     wr_addr,
    output tlas_pkg::step_t                   wr_data,
    output logic                              done,
    output logic [$clog2(STEP_SLOTS+1)-1:0]   total
);

    localparam int AW = $clog2(STEP_SLOTS);
    localparam int CW = $clog2(STEP_SLOTS + 1);
    localparam logic [CW:0] SLOTS_X = (CW+1)'(STEP_SLOTS);

    tlas_pkg::bld_state_t state_reg, state_next;
    tlas_pkg::mode_t      code_reg, code_next;
    logic [4:0]           mask_reg, mask_next;
    logic [2:0]           mod_reg, mod_next;
    logic [3:0]           beat_reg, beat_next;
    logic                 half_reg, half_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [2:0]           j_reg, j_next;

    logic [CW:0]          n_x;
    logic [3:0]           cur_beeps;
    logic                 full;
    logic                 last_pair;
    logic [2:0]           fix_len;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlas_pkg::BLD_IDLE;
            code_reg  <= tlas_pkg::MODE_TICK;
            mask_reg  <= '0;
            mod_reg   <= '0;
            beat_reg  <= '0;
            half_reg  <= 1'b0;
            n_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            mask_reg  <= mask_next;
            mod_reg   <= mod_next;
            beat_reg  <= beat_next;
            half_reg  <= half_next;
            n_reg     <= n_next;
            j_reg     <= j_next;
        end
    end

    // capacity and last gap checks
    always_comb
    begin
        n_x       = {1'b0, n_reg};
        cur_beeps = (mod_reg < 3'(tlas_pkg::NUM_MODULES)) ? beeps[mod_reg] : 4'd0;
        full      = (n_x + (CW+1)'(2)) >= SLOTS_X;
        last_pair = (beat_reg == cur_beeps - 4'd1) || ((n_x + (CW+1)'(4)) >= SLOTS_X);
        fix_len   = tlas_pkg::pattern_len(code_reg);
    end

    // next state and write port
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        mask_next  = mask_reg;
        mod_next   = mod_reg;
        beat_next  = beat_reg;
        half_next  = half_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        done       = 1'b0;
        total      = '0;

        unique case (state_reg)
            tlas_pkg::BLD_IDLE:
            begin
                if (req.start)
                begin
                    code_next = req.code;
                    mask_next = req.mask;
                    mod_next  = '0;
                    beat_next = '0;
                    half_next = 1'b0;
                    n_next    = '0;
                    j_next    = '0;
                    if (req.code == tlas_pkg::MODE_ERROR)
                    begin
                        state_next = tlas_pkg::BLD_ERR;
                    end
                    else
                    begin
                        state_next = tlas_pkg::BLD_FIXED;
                    end
                end
            end
            tlas_pkg::BLD_FIXED:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
                wr_data = tlas_pkg::pattern_step(code_reg, j_reg);
                j_next  = j_reg + 3'd1;
                if (j_reg == fix_len - 3'd1)
                begin
                    done       = 1'b1;
                    total      = CW'(fix_len);
                    state_next = tlas_pkg::BLD_IDLE;
                end
            end
            tlas_pkg::BLD_ERR:
            begin
                if (mod_reg == 3'(tlas_pkg::NUM_MODULES))
                begin
                    // no beeps at all: play the fallback from the table
                    if (n_reg == '0)
                    begin
                        j_next     = '0;
                        state_next = tlas_pkg::BLD_FIXED;
                    end
                    else
                    begin
                        done       = 1'b1;
                        total      = n_reg;
                        state_next = tlas_pkg::BLD_IDLE;
                    end
                end
                else if (!mask_reg[mod_reg] || (beat_reg >= cur_beeps) || full)
                begin
                    mod_next  = mod_reg + 3'd1;
                    beat_next = '0;
                    half_next = 1'b0;
                end
                else if (!half_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = n_reg[AW-1:0];
                    wr_data   = tlas_pkg::BEEP_STEP;
                    half_next = 1'b1;
                end
                else
                begin
                    // gap after a beep, stretched when it closes the module
                    wr_en        = 1'b1;
                    wr_addr      = AW'(n_reg + CW'(1));
                    wr_data      = '0;
                    wr_data.dur  = last_pair ? tlas_pkg::GAP_LAST_DUR : tlas_pkg::GAP_DUR;
                    n_next       = n_reg + CW'(2);
                    beat_next    = beat_reg + 4'd1;
                    half_next    = 1'b0;
                end
            end
            default:
            begin
                state_next = tlas_pkg::BLD_IDLE;
            end
        endcase
    end

endmodule

[design/tone_light_alert_sequencer_unit.sv]
// tone light alert sequencer top level: handshakes, configuration, play
// control and result register; depends on tlas_pkg, tlas_ram, tlas_builder
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  mode, system mode, imu flag, error bits
// m_axis    out  m_axis_tvalid / m_axis_tready  buzzer and led commands, playing flag
// cfg       in   cfg_valid / cfg_ready          beep count registers 0..4
//
// a tick that keeps or ends the current step loads its result straight into
// the output register; a tick that moves to the next step reads the step
// store first. A trigger starts the loader, and no item is taken until the
// pattern is in the step store: a fixed pattern step by step, an error
// pattern as beep and gap pairs, module by module, at most STEP_SLOTS - 2
// steps, or the fallback when no module beeps. The step store needs no
// clearing after reset. A stalled result holds in the output register;
// the next item is taken once that register is free or drains.
module tone_light_alert_sequencer_unit #(
    parameter int STEP_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // mode[2:0], system_mode[5:3], imu_preparing[6], error_mask[11:7], zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // buzzer_write[0], buzzer_freq[12:1], led_write[13], led_breathing[14],
    // led_red[22:15], led_green[30:23], led_blue[38:31], playing[39]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int AW = $clog2(STEP_SLOTS);
    localparam int CW = $clog2(STEP_SLOTS + 1);

    tlas_pkg::top_state_t state_reg, state_next;
    logic                 playing_reg, playing_next;
    tlas_pkg::mode_t      cur_reg, cur_next;
    logic [9:0]           timer_reg, timer_next;
    logic [CW-1:0]        index_reg, index_next;
    logic [CW-1:0]        total_reg, total_next;
    logic                 muted_reg, muted_next;
    logic [tlas_pkg::NUM_MODULES-1:0][3:0] beeps_reg;
    logic                 out_valid_reg, out_valid_next;
    tlas_pkg::result_t    out_reg, out_next;

    logic                 in_accept;
    tlas_pkg::mode_t      in_mode;
    logic [2:0]           in_sysm;
    logic                 in_prep;
    logic [4:0]           in_mask;
    logic                 in_muted;
    logic [CW-1:0]        idx_inc;
    logic                 any_beep;
    tlas_pkg::step_t      first_step;
    tlas_pkg::result_t    res;
    logic                 produce;

    tlas_pkg::bld_req_t   bld_req;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_wr_addr;
    tlas_pkg::step_t      ram_wr_data;
    logic                 ram_rd_en;
    tlas_pkg::step_t      ram_rd_data;
    logic                 bld_done;
    logic [CW-1:0]        bld_total;

    // input transaction decode
    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign in_mode   = tlas_pkg::mode_t'(s_axis_tdata[2:0]);
    assign in_sysm   = s_axis_tdata[5:3];
    assign in_prep   = s_axis_tdata[6];
    assign in_mask   = s_axis_tdata[11:7];
    assign in_muted  = in_prep && (in_sysm != tlas_pkg::SYS_INIT);
    assign idx_inc   = index_reg + CW'(1);

    assign s_axis_tready = (state_reg == tlas_pkg::TOP_IDLE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign cfg_ready     = 1'b1;

    // first step of a starting pattern
    always_comb
    begin
        any_beep = 1'b0;
        for (int i = 0; i < tlas_pkg::NUM_MODULES; i++)
        begin
            any_beep = any_beep | (in_mask[i] & (beeps_reg[i] != 4'd0));
        end
        if (in_mode == tlas_pkg::MODE_ERROR && any_beep)
        begin
            first_step = tlas_pkg::BEEP_STEP;
        end
        else
        begin
            first_step = tlas_pkg::pattern_step(in_mode, 3'd0);
        end
    end

    // step store
    tlas_ram #(
        .WIDTH (tlas_pkg::STEP_W),
        .DEPTH (STEP_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_inc[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // pattern loader
    tlas_builder #(
        .STEP_SLOTS (STEP_SLOTS)
    ) u_builder (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (bld_req),
        .beeps   (beeps_reg),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .done    (bld_done),
        .total   (bld_total)
    );

    // beep count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beeps_reg[0] <= 4'd1;
            beeps_reg[1] <= 4'd2;
            beeps_reg[2] <= 4'd3;
            beeps_reg[3] <= 4'd4;
            beeps_reg[4] <= 4'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tlas_pkg::CFG_BEEPS_CHASSIS: beeps_reg[0] <= cfg_data;
                tlas_pkg::CFG_BEEPS_GIMBAL:  beeps_reg[1] <= cfg_data;
                tlas_pkg::CFG_BEEPS_SHOOTER: beeps_reg[2] <= cfg_data;
                tlas_pkg::CFG_BEEPS_VISION:  beeps_reg[3] <= cfg_data;
                tlas_pkg::CFG_BEEPS_IMU:     beeps_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlas_pkg::TOP_IDLE;
            playing_reg   <= 1'b0;
            cur_reg       <= tlas_pkg::MODE_TICK;
            timer_reg     <= '0;
            index_reg     <= '0;
            total_reg     <= '0;
            muted_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            playing_reg   <= playing_next;
            cur_reg       <= cur_next;
            timer_reg     <= timer_next;
            index_reg     <= index_next;
            total_reg     <= total_next;
            muted_reg     <= muted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // play control: ticks, triggers, step reads and pattern loads
    always_comb
    begin
        state_next   = state_reg;
        playing_next = playing_reg;
        cur_next     = cur_reg;
        timer_next   = timer_reg;
        index_next   = index_reg;
        total_next   = total_reg;
        muted_next   = muted_reg;
        res          = '0;
        produce      = 1'b0;
        ram_rd_en    = 1'b0;
        bld_req      = '0;

        unique case (state_reg)
            tlas_pkg::TOP_IDLE:
            begin
                if (in_accept)
                begin
                    produce = 1'b1;
                    case (in_mode) inside
                        tlas_pkg::MODE_TICK:
                        begin
                            if (in_muted)
                            begin
                                res.buzzer_write = 1'b1;
                            end
                            if (playing_reg)
                            begin
                                if (timer_reg != 10'd0)
                                begin
                                    timer_next = timer_reg - 10'd1;
                                end
                                else
                                begin
                                    index_next = idx_inc;
                                    if (idx_inc < total_reg)
                                    begin
                                        // next step comes from the store
                                        ram_rd_en  = 1'b1;
                                        muted_next = in_muted;
                                        produce    = 1'b0;
                                        state_next = tlas_pkg::TOP_READ;
                                    end
                                    else
                                    begin
                                        // pattern end
                                        res.buzzer_write = 1'b1;
                                        res.buzzer_freq  = '0;
                                        res.led_write    = 1'b1;
                                        if (in_sysm == tlas_pkg::SYS_NORMAL)
                                        begin
                                            res.led_breathing = 1'b1;
                                            res.led_green     = 8'd255;
                                        end
                                        playing_next = 1'b0;
                                        cur_next     = tlas_pkg::MODE_TICK;
                                    end
                                end
                            end
                        end
                        tlas_pkg::MODE_INIT, tlas_pkg::MODE_HINT, tlas_pkg::MODE_LOST,
                        tlas_pkg::MODE_RECOVER, tlas_pkg::MODE_ERROR:
                        begin
                            if (!(playing_reg && cur_reg == in_mode) &&
                                !(playing_reg && in_mode == tlas_pkg::MODE_HINT))
                            begin
                                cur_next          = in_mode;
                                index_next        = '0;
                                playing_next      = 1'b1;
                                timer_next        = first_step.dur;
                                res.buzzer_write  = 1'b1;
                                res.buzzer_freq   = in_muted ? 12'd0 : first_step.tone;
                                res.led_write     = 1'b1;
                                res.led_red       = first_step.red;
                                res.led_green     = first_step.green;
                                res.led_blue      = first_step.blue;
                                bld_req.start     = 1'b1;
                                bld_req.code      = in_mode;
                                bld_req.mask      = in_mask;
                                state_next        = tlas_pkg::TOP_LOAD;
                            end
                        end
                        default: ;
                    endcase
                    res.playing = playing_next;
                end
            end
            tlas_pkg::TOP_READ:
            begin
                produce          = 1'b1;
                timer_next       = ram_rd_data.dur;
                res.buzzer_write = 1'b1;
                res.buzzer_freq  = muted_reg ? 12'd0 : ram_rd_data.tone;
                res.led_write    = 1'b1;
                res.led_red      = ram_rd_data.red;
                res.led_green    = ram_rd_data.green;
                res.led_blue     = ram_rd_data.blue;
                res.playing      = 1'b1;
                state_next       = tlas_pkg::TOP_IDLE;
            end
            tlas_pkg::TOP_LOAD:
            begin
                if (bld_done)
                begin
                    total_next = bld_total;
                    state_next = tlas_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = tlas_pkg::TOP_IDLE;
            end
        endcase
    end

    // output register: hold while stalled, load on a new result
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next       = out_reg;
        if (produce)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

endmodule
